FILE: src/aacr_pkg.sv
// Package for the AABB axis collision resolver: widths, table depth, state codes,
// controller/datapath command and status structs. No dependencies.
package aacr_pkg;

	localparam int TableDepth = 64;
	localparam int IdxW       = $clog2(TableDepth);
	localparam int CntW       = IdxW + 1;
	localparam int PosW       = 24;
	localparam int SizeW      = 20;
	localparam int VelW       = 20;
	localparam int DtW        = 16;
	localparam int CfgW       = 16;
	localparam int CfgIdxW    = 1;

	localparam logic [CfgIdxW-1:0] CFG_MAX_DT    = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_BOX_COUNT = 1'b1;

	localparam logic [15:0] MaxDtReset = 16'd6554;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOVE,
		ST_READ,
		ST_TEST,
		ST_DONE
	} aacr_state_t;

	// controller -> datapath
	typedef struct packed {
		logic            capture;   // latch input word
		logic            move;      // apply velocity on current axis
		logic            rd;        // issue table read
		logic [IdxW-1:0] rd_idx;
		logic            test;      // overlap test / resolve on current axis
		logic            axis_y;    // 0 = x, 1 = y
		logic            finish;    // drive result
	} aacr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip;       // item is a load or skipped
	} aacr_sts_t;

	function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW+2:0] v);
		logic signed [PosW+2:0] hi;
		logic signed [PosW+2:0] lo;
		hi = (PosW+3)'(2**(PosW-1) - 1);
		lo = -(PosW+3)'(2**(PosW-1));
		if (v > hi) return hi[PosW-1:0];
		else if (v < lo) return lo[PosW-1:0];
		else return v[PosW-1:0];
	endfunction

endpackage

FILE: src/aacr_ctrl.sv
// Controller state machine: sequences move, x sweep, move, y sweep per resolve word.
// Depends on aacr_pkg.
module aacr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [aacr_pkg::CntW-1:0] box_count,
	input  aacr_pkg::aacr_sts_t  sts,
	output aacr_pkg::aacr_cmd_t  cmd,
	output logic                 busy
);
	import aacr_pkg::*;

	aacr_state_t state_q, state_d;
	logic [IdxW-1:0] idx_q, idx_d;
	logic axis_q, axis_d;
	logic [CntW-1:0] n;

	assign n = (box_count > CntW'(TableDepth)) ? CntW'(TableDepth) : box_count;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			axis_q  <= axis_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		axis_d  = axis_q;
		cmd     = '0;
		cmd.rd_idx = idx_q;
		cmd.axis_y = axis_q;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					axis_d = 1'b0;
					idx_d  = '0;
					state_d = ST_MOVE;
				end
			end
			ST_MOVE: begin
				if (sts.skip) state_d = ST_DONE;
				else begin
					cmd.move = 1'b1;
					idx_d = '0;
					state_d = (n == '0) ? (axis_q ? ST_DONE : ST_MOVE) : ST_READ;
					if (n == '0) axis_d = 1'b1;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				cmd.test = 1'b1;
				if ({1'b0, idx_q} == n - CntW'(1)) begin
					idx_d = '0;
					if (axis_q) state_d = ST_DONE;
					else begin
						axis_d = 1'b1;
						state_d = ST_MOVE;
					end
				end else begin
					idx_d = idx_q + IdxW'(1);
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: src/aacr_dp.sv
// Datapath: box table memory, moving box registers, move and overlap-resolve arithmetic.
// Depends on aacr_pkg.
module aacr_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  aacr_pkg::aacr_cmd_t               cmd,
	output aacr_pkg::aacr_sts_t               sts,
	input  logic [aacr_pkg::DtW-1:0]          max_dt,
	input  logic                              req_type,
	input  logic [5:0]                        entry_index,
	input  logic signed [aacr_pkg::PosW-1:0]  pos_x,
	input  logic signed [aacr_pkg::PosW-1:0]  pos_y,
	input  logic [aacr_pkg::SizeW-1:0]        width,
	input  logic [aacr_pkg::SizeW-1:0]        height,
	input  logic signed [aacr_pkg::VelW-1:0]  vel_x,
	input  logic signed [aacr_pkg::VelW-1:0]  vel_y,
	input  logic [aacr_pkg::SizeW-1:0]        friction,
	input  logic [aacr_pkg::DtW-1:0]          delta_time,
	input  logic                              step_done,
	input  logic                              was_in_air,
	output logic signed [aacr_pkg::PosW-1:0]  new_pos_x,
	output logic signed [aacr_pkg::PosW-1:0]  new_pos_y,
	output logic signed [aacr_pkg::VelW-1:0]  new_vel_x,
	output logic signed [aacr_pkg::VelW-1:0]  new_vel_y,
	output logic                              in_air,
	output logic                              step_completed,
	output logic                              skipped,
	output logic                              result_valid
);
	import aacr_pkg::*;

	localparam int EntW = 2*PosW + 3*SizeW;
	localparam int WideW = PosW + 3;
	localparam int ProdW = VelW + DtW + 1;

	// box table
	logic [EntW-1:0] mem [TableDepth];
	logic [EntW-1:0] ent_s1;

	// moving box
	logic signed [PosW-1:0] px_q, py_q;
	logic [SizeW-1:0] w_q, h_q;
	logic signed [VelW-1:0] vx_q, vy_q;
	logic [DtW-1:0] dt_q;
	logic air_q, comp_q, skip_q, load_q;

	// table write on load words, registered read
	always_ff @(posedge clk) begin
		if (cmd.capture && !req_type && ({26'd0, entry_index} < TableDepth))
			mem[entry_index[IdxW-1:0]] <= {pos_x, pos_y, width, height, friction};
		if (cmd.rd) ent_s1 <= mem[cmd.rd_idx];
	end

	logic signed [PosW-1:0] bl, bt;
	logic [SizeW-1:0] bw, bh, bf;
	assign {bl, bt, bw, bh, bf} = ent_s1;

	// move on current axis: floor(v*dt/2^16)
	logic signed [VelW-1:0] v_cur;
	logic signed [ProdW-1:0] prod;
	logic signed [WideW-1:0] moved;
	assign v_cur = cmd.axis_y ? vy_q : vx_q;
	assign prod  = v_cur * $signed({1'b0, dt_q});
	assign moved = WideW'(cmd.axis_y ? py_q : px_q) + WideW'(prod >>> DtW);

	// overlap test
	logic signed [WideW-1:0] ax, ay, aw, ah, bxw, byw, bww, bhw;
	logic hit;
	assign ax  = WideW'(px_q);
	assign ay  = WideW'(py_q);
	assign aw  = WideW'({1'b0, w_q});
	assign ah  = WideW'({1'b0, h_q});
	assign bxw = WideW'(bl);
	assign byw = WideW'(bt);
	assign bww = WideW'({1'b0, bw});
	assign bhw = WideW'({1'b0, bh});
	assign hit = !((ax + aw <= bxw) || (ax >= bxw + bww) ||
		(ay + ah <= byw) || (ay >= byw + bhw));

	// friction loss
	logic [SizeW+DtW-1:0] lprod;
	logic [SizeW:0] loss;
	logic [VelW:0] mag;
	assign lprod = bf * dt_q;
	assign loss  = (SizeW+1)'(lprod >> DtW);
	assign mag   = vx_q[VelW-1] ? (VelW+1)'(-$signed({vx_q[VelW-1], vx_q}))
		: (VelW+1)'({1'b0, vx_q});

	assign sts.skip = skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= cmd.finish;
	end

	// moving box registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= pos_x; py_q <= pos_y; w_q <= width; h_q <= height;
			vx_q <= vel_x; vy_q <= vel_y; dt_q <= delta_time;
			load_q <= !req_type;
			if (!req_type) begin
				skip_q <= 1'b1; air_q <= 1'b0; comp_q <= 1'b0;
			end else if (step_done || delta_time > max_dt) begin
				skip_q <= 1'b1; air_q <= was_in_air; comp_q <= step_done;
			end else begin
				skip_q <= 1'b0; air_q <= 1'b1; comp_q <= 1'b1;
			end
		end
		if (cmd.move) begin
			if (cmd.axis_y) py_q <= sat_pos(moved);
			else px_q <= sat_pos(moved);
		end
		if (cmd.test && hit) begin
			if (!cmd.axis_y) begin
				if (!vx_q[VelW-1] && vx_q != '0) px_q <= sat_pos(bxw - aw);
				else if (vx_q[VelW-1]) px_q <= sat_pos(bxw + bww);
				vx_q <= '0;
			end else begin
				if (!vy_q[VelW-1] && vy_q != '0) begin
					py_q <= sat_pos(byw - ah);
					air_q <= 1'b0;
					if (mag <= (VelW+1)'(loss)) vx_q <= '0;
					else if (!vx_q[VelW-1]) vx_q <= vx_q - VelW'(loss);
					else vx_q <= vx_q + VelW'(loss);
				end else if (vy_q[VelW-1]) py_q <= sat_pos(byw + bhw);
				vy_q <= '0;
			end
		end
	end

	assign new_pos_x      = load_q ? '0 : px_q;
	assign new_pos_y      = load_q ? '0 : py_q;
	assign new_vel_x      = load_q ? '0 : vx_q;
	assign new_vel_y      = load_q ? '0 : vy_q;
	assign in_air         = air_q;
	assign step_completed = comp_q;
	assign skipped        = skip_q;
endmodule

FILE: src/aabb_axis_collision_resolver_core.sv
// Top level of the AABB axis collision resolver: config registers, controller, datapath.
// Depends on aacr_pkg, aacr_ctrl, aacr_dp.
//
// channel   | handshake             | payload
// request   | start / busy          | req_type .. was_in_air
// result    | result_valid (strobe) | new_pos_x .. skipped
// config    | cfg_we                | cfg_idx, cfg_data
//
// A load or skipped word goes from the move state straight to the done state. A resolve
// word moves and sweeps each axis in turn over N = active entries: the single table read
// port gives one entry per read and test state pair per axis.
// Reset clears config to defaults and the controller to idle; the table is not cleared.
// The result strobe lasts one cycle; the receiver cannot stall it.
module aabb_axis_collision_resolver_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cfg_we,
	input  logic [aacr_pkg::CfgIdxW-1:0]      cfg_idx,
	input  logic [aacr_pkg::CfgW-1:0]         cfg_data,
	input  logic                              req_type,
	input  logic [5:0]                        entry_index,
	input  logic signed [aacr_pkg::PosW-1:0]  pos_x,
	input  logic signed [aacr_pkg::PosW-1:0]  pos_y,
	input  logic [aacr_pkg::SizeW-1:0]        width,
	input  logic [aacr_pkg::SizeW-1:0]        height,
	input  logic signed [aacr_pkg::VelW-1:0]  vel_x,
	input  logic signed [aacr_pkg::VelW-1:0]  vel_y,
	input  logic [aacr_pkg::SizeW-1:0]        friction,
	input  logic [aacr_pkg::DtW-1:0]          delta_time,
	input  logic                              step_done,
	input  logic                              was_in_air,
	output logic                              result_valid,
	output logic signed [aacr_pkg::PosW-1:0]  new_pos_x,
	output logic signed [aacr_pkg::PosW-1:0]  new_pos_y,
	output logic signed [aacr_pkg::VelW-1:0]  new_vel_x,
	output logic signed [aacr_pkg::VelW-1:0]  new_vel_y,
	output logic                              in_air,
	output logic                              step_completed,
	output logic                              skipped
);
	import aacr_pkg::*;

	logic [DtW-1:0] max_dt_q;
	logic [6:0] box_count_q;
	aacr_cmd_t cmd;
	aacr_sts_t sts;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dt_q    <= MaxDtReset;
			box_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_DT:    max_dt_q <= cfg_data;
				CFG_BOX_COUNT: box_count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	aacr_ctrl u_ctrl (
		.clk, .arst_n, .start,
		.box_count(box_count_q[CntW-1:0]),
		.sts, .cmd, .busy
	);

	aacr_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.max_dt(max_dt_q),
		.req_type, .entry_index, .pos_x, .pos_y, .width, .height,
		.vel_x, .vel_y, .friction, .delta_time, .step_done, .was_in_air,
		.new_pos_x, .new_pos_y, .new_vel_x, .new_vel_y,
		.in_air, .step_completed, .skipped, .result_valid
	);

	// a result only ever follows an accepted word
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without busy");
	// a strobe returns the block to idle
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("busy after result");
	// no two strobes back to back
	a_res_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("double result");
endmodule
